FILE: design/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared constants, word types and the engine state type.
// ----------------------------------------------------------------------------
package lzw_pkg;

  // Dictionary geometry.
  localparam int MAX_CODES  = 4096;
  localparam int CODE_W     = $clog2(MAX_CODES);
  localparam int NFC_W      = CODE_W + 1;
  localparam int SLOT_W     = CODE_W + 8;
  localparam int TABLE_SIZE = MAX_CODES * 256;
  localparam int BITS_W     = 4;

  // First code handed out after the literal bytes, and the restart width.
  localparam logic [NFC_W-1:0]  FIRST_FREE = NFC_W'(256);
  localparam logic [NFC_W-1:0]  NFC_MAX    = NFC_W'(MAX_CODES);
  localparam logic [BITS_W-1:0] MIN_BITS   = BITS_W'(8);

  // Front queue and result queue depths.
  localparam int FQ_DEPTH  = 2;
  localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  // Input word as seen on the push side.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_word_t;

  // Result word as seen on the pop side.
  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic [BITS_W-1:0] code_bits;
    logic              stream_end;
  } code_word_t;

  // Classified byte held in the front queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
    logic       first_byte;
  } item_t;

  // Head of the front queue toward the engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Up to two result words written in one cycle, packed from slot 0.
  typedef struct packed {
    logic [1:0] count;
    code_word_t w0;
    code_word_t w1;
  } res_wr_t;

  // Engine sequencing.
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_OWNER,
    ENG_DECIDE
  } eng_state_t;

endpackage

FILE: design/lzw_front.sv
// ----------------------------------------------------------------------------
// LZW front end
// Accepts input words, marks the first byte of each stream and holds them
// in a short queue for the engine.
// ----------------------------------------------------------------------------
module lzw_front import lzw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  byte_word_t  byte_word,
  output queue_head_t head,
  input  logic        head_pop
);

  item_t               queue_mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_PTR_W:0]   count;
  logic [FQ_PTR_W:0]   count_next;
  logic                have_prefix;
  logic                accept;
  logic                take;

  // Handshake on both sides of the queue.
  assign full       = (count == (FQ_PTR_W+1)'(FQ_DEPTH));
  assign accept     = push && !full;
  assign take       = head_pop && head.valid;
  assign head.valid = (count != '0);
  assign head.item  = queue_mem[rd_ptr];

  // Occupancy after this cycle's accept and take.
  always_comb begin
    count_next = count;
    if (accept && !take) begin
      count_next = count + (FQ_PTR_W+1)'(1);
    end else if (take && !accept) begin
      count_next = count - (FQ_PTR_W+1)'(1);
    end
  end

  // Queue storage; a byte is first when no stream is open.
  always_ff @(posedge clk) begin
    if (accept) begin
      queue_mem[wr_ptr] <= '{data_byte:  byte_word.data_byte,
                             final_byte: byte_word.final_byte,
                             first_byte: !have_prefix};
    end
  end

  // Pointers, count and stream tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
      have_prefix <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        wr_ptr      <= wr_ptr + FQ_PTR_W'(1);
        have_prefix <= !byte_word.final_byte;
      end
      if (take) begin
        rd_ptr <= rd_ptr + FQ_PTR_W'(1);
      end
    end
  end

endmodule

FILE: design/lzw_engine.sv
// ----------------------------------------------------------------------------
// LZW engine
// Looks each byte up in the child table, checks the entry against the owner
// table, and on a miss adds the new code and writes the result words. After
// reset the child table is zeroed once, one entry per cycle.
// ----------------------------------------------------------------------------
module lzw_engine import lzw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        head_pop,
  input  logic        res_room,
  output res_wr_t     res_wr
);

  localparam int LIM_W = 2**BITS_W + 1;

  eng_state_t        state;
  eng_state_t        state_next;
  logic [CODE_W-1:0] prefix_code;
  logic [CODE_W-1:0] prefix_next;
  logic [NFC_W-1:0]  next_free_code;
  logic [NFC_W-1:0]  next_free_code_next;
  logic [BITS_W-1:0] width_now;
  logic [BITS_W-1:0] width_now_next;

  // Dictionary memories. The owner table records the slot that each code
  // was stored under, so stale entries never count as hits.
  logic [CODE_W-1:0] child_mem [TABLE_SIZE];
  logic [SLOT_W-1:0] owner_mem [MAX_CODES];

  // Zeroing pass over the child table after reset.
  logic              clearing;
  logic [SLOT_W-1:0] clr_addr;

  item_t             cur;
  logic [SLOT_W-1:0] slot_q;
  logic [CODE_W-1:0] child_rd;
  logic              bypass;
  logic [CODE_W-1:0] bypass_code;
  logic [CODE_W-1:0] child_code;
  logic [CODE_W-1:0] child_q;
  logic [SLOT_W-1:0] owner_rd;

  logic              issue;
  logic              decide;
  logic [CODE_W-1:0] issue_prefix;
  logic [SLOT_W-1:0] rd_slot;

  logic [NFC_W-1:0]  nfc_a;
  logic [BITS_W-1:0] width_a;
  logic              hit;
  logic              miss;
  logic [CODE_W-1:0] prefix_b;
  logic [NFC_W-1:0]  nfc_b;
  logic [BITS_W-1:0] width_c;
  logic              child_we;
  logic [CODE_W-1:0] child_wdata;
  code_word_t        miss_word;
  code_word_t        end_word;

  // Width grows by one once the next free code passes 2^width.
  function automatic logic [BITS_W-1:0] grown_width(logic [NFC_W-1:0]  nfc,
                                                    logic [BITS_W-1:0] w);
    logic [LIM_W-1:0] lim;
    lim = LIM_W'(1) << w;
    if (LIM_W'(nfc) > lim) begin
      grown_width = w + BITS_W'(1);
    end else begin
      grown_width = w;
    end
  endfunction

  // Sequencer outputs. No byte is issued while the table is being zeroed.
  always_comb begin
    decide   = (state == ENG_DECIDE) && res_room;
    issue    = head.valid && !clearing && ((state == ENG_IDLE) || decide);
    head_pop = issue;
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE: begin
        if (issue) begin
          state_next = ENG_OWNER;
        end
      end
      ENG_OWNER: begin
        state_next = ENG_DECIDE;
      end
      ENG_DECIDE: begin
        if (decide) begin
          state_next = issue ? ENG_OWNER : ENG_IDLE;
        end
      end
      default: begin
        state_next = ENG_IDLE;
      end
    endcase
  end

  // Decision for the byte in flight: width update, hit check, new code.
  always_comb begin
    nfc_a   = next_free_code;
    width_a = width_now;
    if (!cur.first_byte) begin
      if (next_free_code == NFC_MAX) begin
        nfc_a   = FIRST_FREE;
        width_a = MIN_BITS;
      end else begin
        width_a = grown_width(next_free_code, width_now);
      end
    end

    hit  = !cur.first_byte &&
           ({1'b0, child_q} >= FIRST_FREE) &&
           ({1'b0, child_q} < nfc_a) &&
           (owner_rd == slot_q);
    miss = !cur.first_byte && !hit;

    prefix_b = CODE_W'(cur.data_byte);
    nfc_b    = nfc_a;
    if (hit) begin
      prefix_b = child_q;
    end else if (miss) begin
      nfc_b = nfc_a + NFC_W'(1);
    end

    // Second width update for the closing code.
    if (nfc_b == NFC_MAX) begin
      width_c = MIN_BITS;
    end else begin
      width_c = grown_width(nfc_b, width_a);
    end

    miss_word   = '{code_out: prefix_code, code_bits: width_a, stream_end: 1'b0};
    end_word    = '{code_out: prefix_b, code_bits: width_c, stream_end: 1'b1};
    child_we    = decide && miss && (nfc_a < NFC_MAX);
    child_wdata = nfc_a[CODE_W-1:0];

    if (cur.final_byte) begin
      prefix_next         = '0;
      next_free_code_next = FIRST_FREE;
      width_now_next      = MIN_BITS;
    end else begin
      prefix_next         = prefix_b;
      next_free_code_next = nfc_b;
      width_now_next      = width_a;
    end
  end

  // Result words for the queue.
  always_comb begin
    res_wr.count = '0;
    if (decide) begin
      res_wr.count = 2'(miss) + 2'(cur.final_byte);
    end
    res_wr.w0 = miss ? miss_word : end_word;
    res_wr.w1 = end_word;
  end

  // Lookup address of the next byte, under the prefix it will see.
  assign issue_prefix = (state == ENG_DECIDE) ? prefix_next : prefix_code;
  assign rd_slot      = {issue_prefix, head.item.data_byte};
  assign child_code   = bypass ? bypass_code : child_rd;

  // Zeroing pass: walks every slot once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + SLOT_W'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Child table: zeroed after reset, written on a miss, read when a byte is
  // issued.
  always_ff @(posedge clk) begin
    if (clearing) begin
      child_mem[clr_addr] <= '0;
    end else if (child_we) begin
      child_mem[slot_q] <= child_wdata;
    end
    if (issue) begin
      child_rd <= child_mem[rd_slot];
    end
  end

  // Owner table: written with the slot of a new code, read with the child.
  always_ff @(posedge clk) begin
    if (child_we) begin
      owner_mem[child_wdata] <= slot_q;
    end
    if (state == ENG_OWNER) begin
      owner_rd <= owner_mem[child_code];
    end
  end

  // Byte in flight, and forwarding when the lookup hits the slot being written.
  always_ff @(posedge clk) begin
    if (issue) begin
      cur         <= head.item;
      slot_q      <= rd_slot;
      bypass      <= child_we && (rd_slot == slot_q);
      bypass_code <= child_wdata;
    end
    if (state == ENG_OWNER) begin
      child_q <= child_code;
    end
  end

  // Control state and dictionary counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ENG_IDLE;
      prefix_code    <= '0;
      next_free_code <= FIRST_FREE;
      width_now      <= MIN_BITS;
    end else begin
      state <= state_next;
      if (decide) begin
        prefix_code    <= prefix_next;
        next_free_code <= next_free_code_next;
        width_now      <= width_now_next;
      end
    end
  end

endmodule

FILE: design/lzw_res_fifo.sv
// ----------------------------------------------------------------------------
// LZW result queue
// Holds result words; takes up to two words a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
module lzw_res_fifo import lzw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  res_wr_t    res_wr,
  output logic       res_room,
  output logic       empty,
  input  logic       pop,
  output code_word_t code_word
);

  code_word_t           fifo_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_PTR_W:0]   count;
  logic                 take;

  // Room for a full two-word write keeps the engine from overrunning.
  assign empty     = (count == '0);
  assign res_room  = (count <= (RES_PTR_W+1)'(RES_DEPTH - 2));
  assign take      = pop && !empty;
  assign code_word = fifo_mem[rd_ptr];

  // Storage writes, packed from the write pointer.
  always_ff @(posedge clk) begin
    if (res_wr.count != 2'd0) begin
      fifo_mem[wr_ptr] <= res_wr.w0;
    end
    if (res_wr.count == 2'd2) begin
      fifo_mem[wr_ptr + RES_PTR_W'(1)] <= res_wr.w1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(res_wr.count);
      count  <= count + (RES_PTR_W+1)'(res_wr.count) - (RES_PTR_W+1)'(take);
      if (take) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
    end
  end

endmodule

FILE: design/lzw_compressor_top.sv
// ----------------------------------------------------------------------------
// LZW compressor top level
// Each byte passes a child-table read and then an owner-table read; the next
// byte's lookup overlaps the decide state of the byte before it, so a new
// byte is taken before the last one is through, unless the result queue has
// no room. Synchronous rst empties both queues, restores the dictionary
// counters and starts a pass that zeroes all 2^20 child table entries; up
// to two bytes are taken meanwhile and wait in the front queue.
// ----------------------------------------------------------------------------
module lzw_compressor_top import lzw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  byte_word_t byte_word,
  output logic       empty,
  input  logic       pop,
  output code_word_t code_word
);

  queue_head_t head;
  logic        head_pop;
  logic        res_room;
  res_wr_t     res_wr;

  // Front end: accept and classify bytes.
  lzw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_word (byte_word),
    .head      (head),
    .head_pop  (head_pop)
  );

  // Engine: dictionary lookup and code generation.
  lzw_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .head_pop (head_pop),
    .res_room (res_room),
    .res_wr   (res_wr)
  );

  // Result queue toward the consumer.
  lzw_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .res_wr    (res_wr),
    .res_room  (res_room),
    .empty     (empty),
    .pop       (pop),
    .code_word (code_word)
  );

endmodule

FILE: design/lzw_checker.sv
// ----------------------------------------------------------------------------
// LZW compressor port checker
// Watches the top-level ports for reset, word hold, width range and the
// start of each new stream.
// ----------------------------------------------------------------------------
module lzw_checker import lzw_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input code_word_t code_word
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A waiting word stays until it is taken.
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(code_word))
    else $error("waiting word changed before pop");

  // Code widths stay between the restart width and the code size.
  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> code_word.code_bits >= MIN_BITS &&
               code_word.code_bits <= BITS_W'(CODE_W))
    else $error("code width out of range");

  // The first word of a new stream is a literal byte at the restart width.
  a_stream_restart: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && code_word.stream_end |=>
      empty || (code_word.code_bits == MIN_BITS &&
                code_word.code_out < CODE_W'(256)))
    else $error("new stream did not start with a literal byte");

endmodule

bind lzw_compressor_top lzw_checker u_checker (.*);

FILE: tb/tb_lzw_compressor_top.sv
// ----------------------------------------------------------------------------
// LZW compressor testbench
// Pushes byte words into lzw_compressor_top and checks every popped code word
// against a behavioral dictionary kept inside the bench, or against the code
// word given by a directed row. A short table of directed bytes comes first,
// then random streams of varied alphabets. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_lzw_compressor_top;
  import lzw_pkg::*;

  // One row of the directed table. When has_code is set, want is the single
  // code word the row must produce; otherwise the dictionary model decides.
  typedef struct packed {
    byte_word_t word;
    logic       has_code;
    code_word_t want;
  } dir_row_t;

  localparam int DIR_ROWS     = 20;
  localparam int RANDOM_BYTES = 430;
  localparam int TAIL_CYCLES  = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  byte_word_t byte_word = '0;
  logic       full;
  logic       empty;
  code_word_t code_word;

  // Dictionary model state.
  logic [CODE_W-1:0] trie_child [int];
  logic [CODE_W-1:0] cur_prefix = '0;
  logic [NFC_W-1:0]  free_code = FIRST_FREE;
  logic [BITS_W-1:0] code_width = MIN_BITS;
  logic              in_stream = 1'b0;

  code_word_t expected_codes [$];
  int         mismatch_count = 0;
  logic       stalls_on = 1'b1;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // Single-byte streams: the byte itself comes back at width 8 as the end.
    '{'{8'h00, 1'b1}, 1'b1, '{12'h000, 4'd8, 1'b1}},
    '{'{8'hFF, 1'b1}, 1'b1, '{12'h0FF, 4'd8, 1'b1}},
    '{'{8'h80, 1'b1}, 1'b1, '{12'h080, 4'd8, 1'b1}},
    '{'{8'h7F, 1'b1}, 1'b1, '{12'h07F, 4'd8, 1'b1}},
    // Alternating pair: hits on learned strings, ends on a miss (two words).
    '{'{8'h61, 1'b0}, 1'b0, '0},
    '{'{8'h62, 1'b0}, 1'b0, '0},
    '{'{8'h61, 1'b0}, 1'b0, '0},
    '{'{8'h62, 1'b0}, 1'b0, '0},
    '{'{8'h61, 1'b0}, 1'b0, '0},
    '{'{8'h62, 1'b0}, 1'b0, '0},
    '{'{8'h61, 1'b0}, 1'b0, '0},
    '{'{8'h62, 1'b1}, 1'b0, '0},
    // Run of one byte: the end mark lands on a hit (one word).
    '{'{8'h61, 1'b0}, 1'b0, '0},
    '{'{8'h61, 1'b0}, 1'b0, '0},
    '{'{8'h61, 1'b1}, 1'b0, '0},
    // Byte extremes inside one stream.
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    '{'{8'h7F, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b0, '0}
  };

  lzw_compressor_top uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_word (byte_word),
    .empty     (empty),
    .pop       (pop),
    .code_word (code_word)
  );

  // Clock: 12 time units per period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the whole run, including the table zeroing after reset.
  initial begin
    #60000000;
    $display("tb: failure");
    $finish;
  end

  // Random idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!stalls_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Width step taken before each lookup and before the closing code: wrap a
  // full dictionary, else widen once the next code no longer fits.
  function automatic void adjust_width();
    if (free_code == NFC_MAX) begin
      trie_child.delete();
      free_code = FIRST_FREE;
      code_width = MIN_BITS;
    end else if (int'(free_code) > (1 << code_width)) begin
      code_width++;
    end
  endfunction

  // Runs one accepted byte through the dictionary and returns its code words.
  function automatic void compress_byte(input byte_word_t w, ref code_word_t outs[$]);
    int key;
    outs.delete();
    if (!in_stream) begin
      cur_prefix = CODE_W'(w.data_byte);
      in_stream = 1'b1;
    end else begin
      adjust_width();
      key = int'({cur_prefix, w.data_byte});
      if (trie_child.exists(key)) begin
        cur_prefix = trie_child[key];
      end else begin
        if (free_code < NFC_MAX) trie_child[key] = free_code[CODE_W-1:0];
        outs.push_back(code_word_t'{cur_prefix, code_width, 1'b0});
        free_code++;
        cur_prefix = CODE_W'(w.data_byte);
      end
    end
    // The end mark flushes the prefix and starts the next stream from scratch.
    if (w.final_byte) begin
      adjust_width();
      outs.push_back(code_word_t'{cur_prefix, code_width, 1'b1});
      trie_child.delete();
      cur_prefix = '0;
      free_code = FIRST_FREE;
      code_width = MIN_BITS;
      in_stream = 1'b0;
    end
  endfunction

  // Pushes one byte word after a random gap and books its expected codes.
  task automatic send_byte(input byte_word_t w, input logic has_code, input code_word_t want);
    int gap;
    code_word_t outs[$];
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    byte_word <= w;
    do @(posedge clk); while (full);
    compress_byte(w, outs);
    if (has_code) begin
      expected_codes.push_back(want);
    end else begin
      foreach (outs[i]) expected_codes.push_back(outs[i]);
    end
  endtask

  // Result side: pop with random stalls and compare against the oldest code.
  initial begin : result_side
    int hold;
    code_word_t want;
    hold = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (expected_codes.size() == 0) begin
          $error("unexpected word: code_out %0d code_bits %0d stream_end %0d",
                 code_word.code_out, code_word.code_bits, code_word.stream_end);
          mismatch_count++;
        end else begin
          want = expected_codes.pop_front();
          if (code_word.code_out !== want.code_out) begin
            $error("code_out: expected %0d, actual %0d", want.code_out, code_word.code_out);
            mismatch_count++;
          end
          if (code_word.code_bits !== want.code_bits) begin
            $error("code_bits: expected %0d, actual %0d", want.code_bits, code_word.code_bits);
            mismatch_count++;
          end
          if (code_word.stream_end !== want.stream_end) begin
            $error("stream_end: expected %0d, actual %0d",
                   want.stream_end, code_word.stream_end);
            mismatch_count++;
          end
        end
      end
      if (hold == 0 && $urandom_range(0, 3) == 0) hold = pick_gap();
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin : byte_side
    int random_bytes;
    int stream_len;
    int mode;
    int spread;
    int pick;
    logic [7:0] base;
    logic [7:0] data;
    byte_word_t w;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(directed_rows[i].word, directed_rows[i].has_code, directed_rows[i].want);
    end

    // Random streams: full-range bytes, or a narrow alphabet that builds long
    // dictionary strings and many hits. The last stream is cut to the budget.
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      stalls_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) stream_len = $urandom_range(1, 12);
      else if (pick < 95) stream_len = $urandom_range(13, 60);
      else stream_len = $urandom_range(100, 300);
      if (stream_len > RANDOM_BYTES - random_bytes) begin
        stream_len = RANDOM_BYTES - random_bytes;
      end
      mode = $urandom_range(0, 2);
      base = 8'($urandom_range(0, 255));
      spread = $urandom_range(0, 3);
      for (int k = 0; k < stream_len; k++) begin
        if (mode == 0) data = 8'($urandom_range(0, 255));
        else data = base + 8'($urandom_range(0, spread));
        w.data_byte = data;
        w.final_byte = (k == stream_len - 1);
        send_byte(w, 1'b0, '0);
        random_bytes++;
      end
    end
    stalls_on = 1'b1;
    push <= 1'b0;

    // Drain, then wait out the TAIL_CYCLES tail for anything extra to show up.
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
